@@ hdl/indexed_priority_queue_poll_assert.svh @@
// Assertion macros for the checker file of the priority queue.
`ifndef INDEXED_PRIORITY_QUEUE_POLL_ASSERT_SVH
`define INDEXED_PRIORITY_QUEUE_POLL_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define IPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define IPQ_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hdl/ipq_pkg.sv @@
// Package with the constants, codes and interface types of the priority queue.
package ipq_pkg;

  // Field widths of the stream beats.
  localparam int EVENT_ID_W     = 10;
  localparam int PRIORITY_REQ_W = 32;
  localparam int POLLED_ID_W    = 10;
  localparam int IN_TDATA_W     = ((EVENT_ID_W + PRIORITY_REQ_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W    = ((POLLED_ID_W + 7) / 8) * 8;

  // Defaults for the top-level parameters.
  localparam int DEF_ID_BITS       = 10;
  localparam int DEF_PRIORITY_BITS = 32;

  // Operation codes carried in in_tuser.
  typedef enum logic {
    OP_SET  = 1'b0,
    OP_POLL = 1'b1
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_clear;    // clear the entry under the counter
    logic wr_set;      // write the accepted set beat into the table
    logic wr_remove;   // drop the active mark of the best entry
    logic scan_start;  // begin a new poll scan
    logic scan_rd;     // read the entry under the counter
    logic out_load;    // load the poll result into the output register
  } ipq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_last;    // counter points at the last entry
    logic have;        // the scan has found an active entry
    logic out_free;    // output register can take a result this cycle
  } ipq_sts_t;

endpackage

@@ hdl/indexed_priority_queue_poll.sv @@
// Top level of the indexed priority queue with poll of the highest priority.
//
// Input stream (in_*): one beat per operation. in_tuser is the operation,
// set or poll. A set writes the priority of one event id and marks it active;
// a poll removes the active id with the highest signed priority, ties going
// to the smallest id.
// Output stream (out_*): one beat per poll carrying the removed id and a
// found flag; found is low and the id zero when no id was active.
// A set beat is written as it is accepted and in_tready stays high after it. A poll
// scan reads one table entry per cycle through the single read port of the
// table memory, then a drain step compares the last entry and a finish step
// writes back and loads the result.
// After reset the block sweeps the table once, clearing the active marks;
// in_tready stays low during the sweep.
// Results sit in an output register, so set beats are still taken while a
// result waits; a poll that finishes while the receiver stalls holds in its
// last step until the output register frees up.
module indexed_priority_queue_poll
  import ipq_pkg::*;
#(
  parameter int ID_BITS       = DEF_ID_BITS,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // event_id, priority_req, zero pad
  input  logic [0:0]             in_tuser,   // operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // polled_id, zero pad
  output logic [0:0]             out_tuser   // found
);

  ipq_cmd_t cmd;
  ipq_sts_t sts;

  // Sequencing of sweeps, set beats and poll scans.
  ipq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser[0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table, scan and result datapath.
  ipq_datapath #(
    .ID_BITS       (ID_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ hdl/ipq_datapath.sv @@
// Datapath of the priority queue: table memory, scan counter, best tracker, output register.
module ipq_datapath
  import ipq_pkg::*;
#(
  parameter int ID_BITS       = DEF_ID_BITS,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ipq_cmd_t               cmd,
  output ipq_sts_t               sts,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [0:0]             out_tuser
);

  localparam int DEPTH = 1 << ID_BITS;

  // Each table word holds the active mark above the priority.
  logic [PRIORITY_BITS:0] mem [DEPTH];

  logic [EVENT_ID_W-1:0]            event_id;
  logic signed [PRIORITY_REQ_W-1:0] priority_req;
  logic [ID_BITS-1:0]               set_id;
  logic signed [PRIORITY_BITS-1:0]  set_prio;

  logic [ID_BITS-1:0]              cnt_r, cnt_nxt;
  logic [PRIORITY_BITS:0]          rd_data_r;
  logic [ID_BITS-1:0]              rd_idx_r;
  logic                            rd_vld_r;
  logic                            have_r, have_nxt;
  logic [ID_BITS-1:0]              best_id_r, best_id_nxt;
  logic signed [PRIORITY_BITS-1:0] best_prio_r, best_prio_nxt;
  logic signed [PRIORITY_BITS-1:0] rd_prio;
  logic                            out_valid_r, out_valid_nxt;
  logic [POLLED_ID_W-1:0]          out_id_r;
  logic                            out_found_r;

  logic                            wr_en;
  logic [ID_BITS-1:0]              wr_addr;
  logic [PRIORITY_BITS:0]          wr_data;

  // Unpack the input beat and fit it to the table geometry.
  assign event_id     = in_tdata[EVENT_ID_W-1:0];
  assign priority_req = signed'(in_tdata[EVENT_ID_W +: PRIORITY_REQ_W]);
  assign set_id       = ID_BITS'(event_id);
  assign set_prio     = PRIORITY_BITS'(priority_req);

  // Single write port: clearing sweep, set beat, or removal of the polled entry.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_data = '0;
    if (cmd.wr_clear) begin
      wr_en = 1'b1;
    end else if (cmd.wr_set) begin
      wr_en   = 1'b1;
      wr_addr = set_id;
      wr_data = {1'b1, set_prio};
    end else if (cmd.wr_remove) begin
      wr_en   = 1'b1;
      wr_addr = best_id_r;
      wr_data = {1'b0, best_prio_r};
    end
  end

  // Table memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.scan_rd) begin
      rd_data_r <= mem[cnt_r];
      rd_idx_r  <= cnt_r;
    end
  end

  // Counter walks the table for the clearing sweep and the poll scan.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.scan_start) begin
      cnt_nxt = '0;
    end else if (cmd.wr_clear || cmd.scan_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Keep the best active entry; a strictly greater priority replaces it,
  // so on equal priorities the smaller id stays.
  assign rd_prio = signed'(rd_data_r[PRIORITY_BITS-1:0]);

  always_comb begin
    have_nxt      = have_r;
    best_id_nxt   = best_id_r;
    best_prio_nxt = best_prio_r;
    if (cmd.scan_start) begin
      have_nxt = 1'b0;
    end else if (rd_vld_r && rd_data_r[PRIORITY_BITS]
                 && (!have_r || (rd_prio > best_prio_r))) begin
      have_nxt      = 1'b1;
      best_id_nxt   = rd_idx_r;
      best_prio_nxt = rd_prio;
    end
  end

  // Output register: loads a result, empties when the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= cmd.scan_rd;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_id_r   <= best_id_nxt;
    best_prio_r <= best_prio_nxt;
    if (cmd.out_load) begin
      out_id_r    <= have_r ? POLLED_ID_W'(best_id_r) : '0;
      out_found_r <= have_r;
    end
  end

  assign sts.cnt_last = &cnt_r;
  assign sts.have     = have_r;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = OUT_TDATA_W'(out_id_r);
  assign out_tuser[0] = out_found_r;

endmodule

@@ hdl/ipq_ctrl.sv @@
// Controller of the priority queue: clearing sweep, set beats and poll scans.
module ipq_ctrl
  import ipq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     in_op,
  input  ipq_sts_t sts,
  output ipq_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;
  logic   accept;

  assign accept    = in_tvalid && in_tready_r;
  assign in_tready = in_tready_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.wr_clear = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (op_t'(in_op) == OP_POLL) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            cmd.wr_set = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.wr_remove = sts.have;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and the registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == ST_IDLE);
    end
  end

endmodule

@@ hdl/ipq_checker.sv @@
// Port checker for the priority queue and its bind to the top level.
`include "indexed_priority_queue_poll_assert.svh"

module ipq_checker
  import ipq_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [0:0]             in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]             out_tuser
);

  // A stalled result beat keeps its contents.
  `IPQ_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")

  // An empty-queue result carries id zero.
  `IPQ_ASSERT(a_empty_id, out_tvalid && !out_tuser[0] |-> out_tdata == '0, "empty poll with nonzero id")

  // A poll beat occupies the block for its scan.
  `IPQ_ASSERT(a_poll_busy, in_tvalid && in_tready && in_tuser[0] == OP_POLL |=> !in_tready, "input taken during a poll scan")

  // A set beat leaves in_tready high in the cycle after it.
  `IPQ_ASSERT(a_set_fast, in_tvalid && in_tready && in_tuser[0] == OP_SET |=> in_tready, "set beat did not finish in one cycle")

endmodule

bind indexed_priority_queue_poll ipq_checker u_ipq_checker (.*);

@@ test/indexed_priority_queue_poll_tb.sv @@
`timescale 1ns / 1ps
// Testbench of the indexed priority queue: directed and random beats checked against a predictor.
module indexed_priority_queue_poll_tb;
  import ipq_pkg::*;

  localparam int DEPTH        = 1 << DEF_ID_BITS;
  localparam int RANDOM_ITEMS = 555;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int PAD_W        = IN_TDATA_W - EVENT_ID_W - PRIORITY_REQ_W;

  localparam logic [PRIORITY_REQ_W-1:0] PRIO_MAX = 32'h7fff_ffff;
  localparam logic [PRIORITY_REQ_W-1:0] PRIO_MIN = 32'h8000_0000;
  localparam logic [PRIORITY_REQ_W-1:0] PRIO_NEG = 32'hffff_ffff;

  // One input beat, with an optional typed-in poll result.
  typedef struct packed {
    op_t                       op;
    logic [EVENT_ID_W-1:0]     id;
    logic [PRIORITY_REQ_W-1:0] prio;
    logic                      typed;
    logic [POLLED_ID_W-1:0]    want_id;
    logic                      want_found;
  } stim_row_t;

  // One poll result.
  typedef struct packed {
    logic [POLLED_ID_W-1:0] id;
    logic                   found;
  } poll_result_t;

  // Directed beats: extremes, ties, update of an active id, reinsert, empty polls.
  localparam int DIR_ROWS = 25;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_POLL, 10'd1023, PRIO_NEG, 1'b1, 10'd0,    1'b0},
    '{OP_SET,  10'd0,    PRIO_MAX, 1'b0, 10'd0,    1'b0},
    '{OP_SET,  10'd1023, PRIO_MIN, 1'b0, 10'd0,    1'b0},
    '{OP_SET,  10'd5,    PRIO_NEG, 1'b0, 10'd0,    1'b0},
    '{OP_POLL, 10'd0,    32'd0,    1'b1, 10'd0,    1'b1},
    '{OP_POLL, 10'd0,    32'd0,    1'b1, 10'd5,    1'b1},
    '{OP_POLL, 10'd0,    32'd0,    1'b1, 10'd1023, 1'b1},
    '{OP_POLL, 10'd0,    32'd0,    1'b1, 10'd0,    1'b0},
    '{OP_SET,  10'd700,  32'd7,    1'b0, 10'd0,    1'b0},
    '{OP_SET,  10'd10,   32'd7,    1'b0, 10'd0,    1'b0},
    '{OP_SET,  10'd3,    32'd7,    1'b0, 10'd0,    1'b0},
    '{OP_POLL, 10'd0,    32'd0,    1'b1, 10'd3,    1'b1},
    '{OP_SET,  10'd10,   -32'sd5,  1'b0, 10'd0,    1'b0},
    '{OP_POLL, 10'd0,    32'd0,    1'b1, 10'd700,  1'b1},
    '{OP_POLL, 10'd0,    32'd0,    1'b1, 10'd10,   1'b1},
    '{OP_SET,  10'd42,   32'd100,  1'b0, 10'd0,    1'b0},
    '{OP_POLL, 10'd0,    32'd0,    1'b1, 10'd42,   1'b1},
    '{OP_SET,  10'd42,   PRIO_MIN, 1'b0, 10'd0,    1'b0},
    '{OP_SET,  10'd1023, PRIO_MIN, 1'b0, 10'd0,    1'b0},
    '{OP_POLL, 10'd0,    32'd0,    1'b1, 10'd42,   1'b1},
    '{OP_POLL, 10'd0,    32'd0,    1'b1, 10'd1023, 1'b1},
    '{OP_SET,  10'd1023, 32'd0,    1'b0, 10'd0,    1'b0},
    '{OP_SET,  10'd0,    32'd0,    1'b0, 10'd0,    1'b0},
    '{OP_POLL, 10'd0,    32'd0,    1'b1, 10'd0,    1'b1},
    '{OP_POLL, 10'd0,    32'd0,    1'b1, 10'd1023, 1'b1}
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // event_id, priority_req, zero pad
  logic [0:0]             in_tuser   = '0;   // operation
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // polled_id, zero pad
  logic [0:0]             out_tuser;         // found

  // Predicted table contents and the polls still owed by the block.
  logic signed [PRIORITY_REQ_W-1:0] prio_table [DEPTH];
  bit                               active_table [DEPTH];
  poll_result_t                     owed_polls [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_stall    = 0;
  bit          tx_calm     = 1'b0;
  bit          rx_calm     = 1'b0;

  always #6 clk = ~clk;

  indexed_priority_queue_poll u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Removes the active id with the highest signed priority, smallest id on ties.
  function automatic poll_result_t take_highest();
    poll_result_t                     res;
    logic signed [PRIORITY_REQ_W-1:0] best;
    bit                               have;
    res  = '0;
    best = '0;
    have = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (active_table[i] && (!have || prio_table[i] > best)) begin
        have   = 1'b1;
        best   = prio_table[i];
        res.id = POLLED_ID_W'(i);
      end
    end
    if (have) begin
      active_table[res.id] = 1'b0;
      res.found            = 1'b1;
    end
    return res;
  endfunction

  // Idle cycles before a beat: mostly short, a few long, none in calm stretches.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (tx_calm || roll < 45) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Priorities that favor ties and the ends of the signed range.
  function automatic logic [PRIORITY_REQ_W-1:0] pick_priority();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      return PRIORITY_REQ_W'($signed($urandom_range(0, 6)) - 3);
    end else if (roll < 40) begin
      case ($urandom_range(0, 5))
        0: return PRIO_MAX;
        1: return PRIO_MIN;
        2: return PRIO_MAX - 1;
        3: return PRIO_MIN + 1;
        4: return PRIO_NEG;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  // Ids that mix the whole range with small pools at both ends for updates.
  function automatic logic [EVENT_ID_W-1:0] pick_id();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      return EVENT_ID_W'($urandom_range(0, DEPTH - 1));
    end else if (roll < 7) begin
      return EVENT_ID_W'($urandom_range(0, 15));
    end
    return EVENT_ID_W'($urandom_range(DEPTH - 8, DEPTH - 1));
  endfunction

  // Presents one beat, waits for the handshake and updates the prediction.
  task automatic send_beat(input stim_row_t row);
    int unsigned  gap;
    poll_result_t res;
    gap = idle_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.op;
    in_tdata  <= {{PAD_W{1'b0}}, row.prio, row.id};
    do @(posedge clk); while (!in_tready);
    if (row.op == OP_SET) begin
      prio_table[row.id]   = row.prio;
      active_table[row.id] = 1'b1;
    end else begin
      res = take_highest();
      if (row.typed) begin
        res.id    = row.want_id;
        res.found = row.want_found;
      end
      owed_polls.push_back(res);
    end
  endtask

  // Receiver pacing: short and long stalls, with stretches of none.
  always @(posedge clk) begin : rx_pace
    int unsigned roll;
    if (cycle_count % 3000 == 0) begin
      rx_calm <= ($urandom_range(0, 3) == 0);
    end
    roll = $urandom_range(0, 99);
    if (rx_stall != 0) begin
      out_tready <= 1'b0;
      rx_stall   <= rx_stall - 1;
    end else if (rx_calm || roll < 60) begin
      out_tready <= 1'b1;
    end else if (roll < 90) begin
      out_tready <= 1'b0;
      rx_stall   <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b0;
      rx_stall   <= $urandom_range(10, 60);
    end
  end

  // Result checking against the oldest owed poll.
  always @(posedge clk) begin : result_check
    poll_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_polls.size() == 0) begin
        $error("result beat with no poll outstanding: polled_id %0d found %0b",
               out_tdata[POLLED_ID_W-1:0], out_tuser[0]);
        error_count++;
      end else begin
        want = owed_polls.pop_front();
        if (out_tdata[POLLED_ID_W-1:0] !== want.id) begin
          $error("polled_id: expected %0d, got %0d", want.id, out_tdata[POLLED_ID_W-1:0]);
          error_count++;
        end
        if (out_tuser[0] !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_tuser[0]);
          error_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:POLLED_ID_W] !== '0) begin
          $error("out_tdata pad: expected 0, got %0h", out_tdata[OUT_TDATA_W-1:POLLED_ID_W]);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[indexed_priority_queue_poll] ERROR");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random fill and drain phases.
  initial begin : stimulus
    stim_row_t row;
    bit        draining;
    for (int i = 0; i < DEPTH; i++) begin
      prio_table[i]   = '0;
      active_table[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_beat(DIRECTED[i]);
    end

    // Fill phases grow the queue; drain phases empty it and poll past empty.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
      end
      draining = ((n / 40) % 2 == 1);
      row      = '0;
      row.id   = pick_id();
      row.prio = pick_priority();
      if ($urandom_range(0, 99) < (draining ? 65 : 15)) begin
        row.op = OP_POLL;
      end else begin
        row.op = OP_SET;
      end
      send_beat(row);
    end
    in_tvalid <= 1'b0;

    // Wait out the remaining polls, then a full scan for stray beats.
    while (owed_polls.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[indexed_priority_queue_poll] OK");
    end else begin
      $display("[indexed_priority_queue_poll] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/ipq_pkg.sv
hdl/ipq_datapath.sv
hdl/ipq_ctrl.sv
hdl/indexed_priority_queue_poll.sv
hdl/ipq_checker.sv
test/indexed_priority_queue_poll_tb.sv
